@@ rtl/tcm_pkg.sv @@
// tcm_pkg: shared constants, types and arithmetic helpers of the tone and chirp mixer.
// Used by tcm_ctrl, tcm_datapath and tone_chirp_mixer_top. No dependencies.
package tcm_pkg;

    localparam int PHASE_BITS_DEF    = 24;
    localparam int SINE_DEPTH_DEF    = 256;
    localparam int CHIRP_SAMPLES_DEF = 2202;
    localparam int CHIRP_ATTACK_DEF  = 110;
    localparam int CHIRP_RELEASE_DEF = 440;

    localparam int STEP_W  = 23;
    localparam int LEVEL_W = 15;
    localparam int SAMP_W  = 16;
    localparam int COUNT_W = 12;
    localparam int CFG_IDX_W = 3;

    localparam int Q_ONE        = 32768;
    localparam int TONE_TARGET  = 3932;
    localparam int GAIN_STEP    = 149;
    localparam int HAZARD_SCALE = 4588;
    localparam int CHIRP_SCALE  = 5243;
    localparam int STEP_RESET   = 762;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TONE_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAZARD_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAZARD_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HAZARD_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HAZARD_PAN    = 3'd5;

    // multiplier operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_TONE = 4'd1,
        OP_HAZ  = 4'd2,
        OP_HL   = 4'd3,
        OP_HR   = 4'd4,
        OP_CH   = 4'd5,
        OP_CV   = 4'd6,
        OP_CL   = 4'd7,
        OP_CR   = 4'd8
    } op_t;

    typedef struct packed {
        logic latch;   // take the input request
        logic evt;     // apply chirp start/stop
        logic prep;    // ramps, sine reads, envelope
        op_t  op;
        logic fin;     // commit state, load output
    } cmd_t;

    typedef struct packed {
        logic idle_frame;
        logic out_free;
    } status_t;

    // Q1.15 product truncated toward zero; b up to 32768
    function automatic logic signed [16:0] mulq15(logic signed [16:0] a, logic [16:0] b);
        logic [16:0] m;
        logic [33:0] p;
        logic [16:0] q;
        m = a[16] ? 17'(-a) : 17'(a);
        p = 34'(m) * 34'(b);
        q = p[31:15];
        return a[16] ? 17'(-q) : 17'(q);
    endfunction

    function automatic logic [15:0] ramp(logic [15:0] g, logic [15:0] t);
        logic [16:0] up;
        logic [16:0] lim;
        up  = 17'(g) + 17'(GAIN_STEP);
        lim = 17'(t) + 17'(GAIN_STEP);
        if (g < t) begin
            return (up > 17'(t)) ? t : up[15:0];
        end else if (g > t) begin
            return (17'(g) > lim) ? 16'(g - 16'(GAIN_STEP)) : t;
        end
        return g;
    endfunction

    function automatic logic [16:0] left_gain(logic signed [15:0] pan);
        return (pan > 0) ? 17'(Q_ONE - int'(pan)) : 17'(Q_ONE);
    endfunction

    function automatic logic [16:0] right_gain(logic signed [15:0] pan);
        return (pan < 0) ? 17'(Q_ONE + int'(pan)) : 17'(Q_ONE);
    endfunction

    // quarter-wave odd polynomial, Q14 coefficients
    function automatic logic signed [15:0] sine_val(int idx, int log2d);
        longint a;
        longint b;
        longint x;
        longint x2;
        longint t;
        longint t2;
        longint s;
        a  = ((longint'(idx) << 16) >> log2d) & 64'hFFFF;
        b  = a & 64'h7FFF;
        x  = (b < 16384) ? b : 32768 - b;
        x2 = (x * x) >> 14;
        t  = 21167 - ((x2 * 2611) >> 14);
        t2 = 51472 - ((x2 * t) >> 14);
        s  = (x * t2) >> 14;
        if (s > 32767) s = 32767;
        return (a >= 32768) ? 16'(-s) : 16'(s);
    endfunction

endpackage

@@ rtl/tcm_ctrl.sv @@
// tcm_ctrl: sequencer of the mixer; steps the shared multiplier through its operations.
// Depends on tcm_pkg.
module tcm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tcm_pkg::status_t   status,
    output tcm_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVT  = 5'b00010,
        S_PREP = 5'b00100,
        S_OP   = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    tcm_pkg::op_t   op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= tcm_pkg::OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EVT;
            end
            S_EVT: state_next = S_PREP;
            S_PREP: begin
                if (status.idle_frame) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_OP;
                    op_next    = tcm_pkg::OP_TONE;
                end
            end
            S_OP: begin
                unique case (op_reg)
                    tcm_pkg::OP_TONE: op_next = tcm_pkg::OP_HAZ;
                    tcm_pkg::OP_HAZ:  op_next = tcm_pkg::OP_HL;
                    tcm_pkg::OP_HL:   op_next = tcm_pkg::OP_HR;
                    tcm_pkg::OP_HR:   op_next = tcm_pkg::OP_CH;
                    tcm_pkg::OP_CH:   op_next = tcm_pkg::OP_CV;
                    tcm_pkg::OP_CV:   op_next = tcm_pkg::OP_CL;
                    tcm_pkg::OP_CL:   op_next = tcm_pkg::OP_CR;
                    default: begin
                        op_next    = tcm_pkg::OP_NONE;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                if (status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cmd.latch = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.evt   = (state_reg == S_EVT);
    assign cmd.prep  = (state_reg == S_PREP);
    assign cmd.op    = (state_reg == S_OP) ? op_reg : tcm_pkg::OP_NONE;
    assign cmd.fin   = (state_reg == S_FIN) && status.out_free;

endmodule

@@ rtl/tcm_datapath.sv @@
// tcm_datapath: config registers, voice state, sine table, shared Q1.15 multiplier, output register.
// Depends on tcm_pkg; driven by tcm_ctrl.
module tcm_datapath #(
    parameter int PHASE_BITS       = tcm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = tcm_pkg::SINE_DEPTH_DEF,
    parameter int CHIRP_SAMPLES    = tcm_pkg::CHIRP_SAMPLES_DEF,
    parameter int CHIRP_ATTACK     = tcm_pkg::CHIRP_ATTACK_DEF,
    parameter int CHIRP_RELEASE    = tcm_pkg::CHIRP_RELEASE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcm_pkg::STEP_W-1:0]        cfg_wdata,
    input  logic [87:0]                       s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    input  tcm_pkg::cmd_t                     cmd,
    output tcm_pkg::status_t                  status
);

    localparam int LOG2D  = $clog2(SINE_TABLE_DEPTH);
    localparam int ATT_Q  = tcm_pkg::Q_ONE / CHIRP_ATTACK;
    localparam int ATT_R  = tcm_pkg::Q_ONE % CHIRP_ATTACK;
    localparam int REL_Q  = tcm_pkg::Q_ONE / CHIRP_RELEASE;
    localparam int REL_R  = tcm_pkg::Q_ONE % CHIRP_RELEASE;
    localparam int REL_Q0 = (CHIRP_SAMPLES * tcm_pkg::Q_ONE) / CHIRP_RELEASE;
    localparam int REL_R0 = (CHIRP_SAMPLES * tcm_pkg::Q_ONE) % CHIRP_RELEASE;
    localparam int RQ_W   = $clog2(REL_Q0 + 1);
    localparam int AR_W   = $clog2(CHIRP_ATTACK + 1);
    localparam int RR_W   = $clog2(CHIRP_RELEASE + 1) + 1;

    // sine table, constant
    logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
        assign sine_rom[i] = tcm_pkg::sine_val(i, LOG2D);
    end

    // configuration
    logic                  tone_en_reg, haz_en_reg;
    logic [22:0]           tone_step_reg, haz_step_reg;
    logic [14:0]           haz_level_reg;
    logic signed [15:0]    haz_pan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_en_reg   <= 1'b0;
            tone_step_reg <= 23'(tcm_pkg::STEP_RESET);
            haz_en_reg    <= 1'b0;
            haz_step_reg  <= 23'(tcm_pkg::STEP_RESET);
            haz_level_reg <= '0;
            haz_pan_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcm_pkg::REG_TONE_ENABLE:   tone_en_reg   <= cfg_wdata[0];
                tcm_pkg::REG_TONE_STEP:     tone_step_reg <= cfg_wdata;
                tcm_pkg::REG_HAZARD_ENABLE: haz_en_reg    <= cfg_wdata[0];
                tcm_pkg::REG_HAZARD_STEP:   haz_step_reg  <= cfg_wdata;
                tcm_pkg::REG_HAZARD_LEVEL:  haz_level_reg <= cfg_wdata[14:0];
                tcm_pkg::REG_HAZARD_PAN:    haz_pan_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic signed [15:0] in_l_reg, in_r_reg;
    logic               start_reg, stop_reg;
    logic [22:0]        cstep_reg;
    logic [14:0]        clevel_reg;
    logic signed [15:0] cpan_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_l_reg   <= s_tdata[15:0];
            in_r_reg   <= s_tdata[31:16];
            cstep_reg  <= s_tdata[54:32];
            clevel_reg <= s_tdata[69:55];
            cpan_reg   <= s_tdata[85:70];
            start_reg  <= s_tuser[0];
            stop_reg   <= s_tuser[1];
        end
    end

    // target and chirp volume, registered products of stable values
    logic [15:0] haz_tgt_reg, vv_reg;
    logic [14:0] cvol_reg;
    logic        haz_on;
    logic [27:0] haz_prod;
    logic [27:0] vv_prod;

    assign haz_on   = haz_en_reg && (haz_level_reg != '0);
    assign haz_prod = 28'(haz_level_reg) * 28'(tcm_pkg::HAZARD_SCALE);
    assign vv_prod  = 28'(cvol_reg) * 28'(tcm_pkg::CHIRP_SCALE);

    always_ff @(posedge aclk) begin
        haz_tgt_reg <= haz_on ? 16'(haz_prod[27:15]) : '0;
        vv_reg      <= 16'(vv_prod[27:15]);
    end

    // voice state
    logic [PHASE_BITS-1:0] tphase_reg, hphase_reg, cphase_reg, cinc_reg;
    logic [15:0]           tgain_reg, hgain_reg;
    logic [tcm_pkg::COUNT_W-1:0] left_reg, age_reg;
    logic signed [15:0]    cbal_reg;
    logic [16:0]           aq_reg;
    logic [AR_W-1:0]       ar_reg;
    logic [RQ_W-1:0]       rq_reg;
    logic [RR_W-1:0]       rr_reg;
    logic                  active_reg, pass_reg;

    // working values
    logic signed [15:0] sin_t_reg, sin_h_reg, sin_c_reg;
    logic [16:0]        env_reg, hlg_reg, hrg_reg, clg_reg, crg_reg;
    logic signed [16:0] tone_reg, h_reg, hl_reg, hr_reg, c_reg, cl_reg, cr_reg;

    logic [15:0] tone_target;
    assign tone_target = tone_en_reg ? 16'(tcm_pkg::TONE_TARGET) : '0;

    assign status.idle_frame = !tone_en_reg && (tgain_reg == '0) && !haz_on
                               && (hgain_reg == '0) && (left_reg == '0);

    // shared multiplier
    logic signed [16:0] mul_a, prod;
    logic [16:0]        mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            tcm_pkg::OP_TONE: begin mul_a = 17'(sin_t_reg); mul_b = 17'(tgain_reg); end
            tcm_pkg::OP_HAZ:  begin mul_a = 17'(sin_h_reg); mul_b = 17'(hgain_reg); end
            tcm_pkg::OP_HL:   begin mul_a = h_reg;          mul_b = hlg_reg;        end
            tcm_pkg::OP_HR:   begin mul_a = h_reg;          mul_b = hrg_reg;        end
            tcm_pkg::OP_CH:   begin mul_a = 17'(sin_c_reg); mul_b = env_reg;        end
            tcm_pkg::OP_CV:   begin mul_a = c_reg;          mul_b = 17'(vv_reg);    end
            tcm_pkg::OP_CL:   begin mul_a = c_reg;          mul_b = clg_reg;        end
            tcm_pkg::OP_CR:   begin mul_a = c_reg;          mul_b = crg_reg;        end
            default: ;
        endcase
    end
    assign prod = tcm_pkg::mulq15(mul_a, mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            cl_reg <= '0;
            cr_reg <= '0;
        end
        unique case (cmd.op)
            tcm_pkg::OP_TONE: tone_reg <= prod;
            tcm_pkg::OP_HAZ:  h_reg    <= prod;
            tcm_pkg::OP_HL:   hl_reg   <= prod;
            tcm_pkg::OP_HR:   hr_reg   <= prod;
            tcm_pkg::OP_CH:   c_reg    <= prod;
            tcm_pkg::OP_CV:   c_reg    <= prod;
            tcm_pkg::OP_CL:   cl_reg   <= active_reg ? prod : '0;
            tcm_pkg::OP_CR:   cr_reg   <= active_reg ? prod : '0;
            default: ;
        endcase
    end

    // release tracker step: left*32768 = rq*REL + rr, stepped down by 32768
    logic signed [RR_W:0] rr_dec;
    assign rr_dec = $signed({1'b0, rr_reg}) - $signed((RR_W+1)'(REL_R));

    logic [AR_W:0] ar_inc;
    assign ar_inc = (AR_W+1)'(ar_reg) + (AR_W+1)'(ATT_R);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            sin_t_reg <= sine_rom[tphase_reg[PHASE_BITS-1 -: LOG2D]];
            sin_h_reg <= sine_rom[hphase_reg[PHASE_BITS-1 -: LOG2D]];
            sin_c_reg <= sine_rom[cphase_reg[PHASE_BITS-1 -: LOG2D]];
            hlg_reg   <= tcm_pkg::left_gain(haz_pan_reg);
            hrg_reg   <= tcm_pkg::right_gain(haz_pan_reg);
            clg_reg   <= tcm_pkg::left_gain(cbal_reg);
            crg_reg   <= tcm_pkg::right_gain(cbal_reg);
            if (32'(age_reg) < CHIRP_ATTACK)        env_reg <= aq_reg;
            else if (32'(left_reg) < CHIRP_RELEASE) env_reg <= 17'(rq_reg);
            else                                    env_reg <= 17'(tcm_pkg::Q_ONE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tphase_reg <= '0;
            hphase_reg <= '0;
            cphase_reg <= '0;
            cinc_reg   <= '0;
            tgain_reg  <= '0;
            hgain_reg  <= '0;
            left_reg   <= '0;
            age_reg    <= '0;
            cvol_reg   <= '0;
            cbal_reg   <= '0;
            aq_reg     <= '0;
            ar_reg     <= '0;
            rq_reg     <= '0;
            rr_reg     <= '0;
            active_reg <= 1'b0;
            pass_reg   <= 1'b0;
        end else begin
            if (cmd.evt) begin
                if (stop_reg || (start_reg && clevel_reg == '0)) begin
                    left_reg <= '0;
                end else if (start_reg) begin
                    cinc_reg   <= PHASE_BITS'(cstep_reg);
                    cvol_reg   <= clevel_reg;
                    cbal_reg   <= cpan_reg;
                    left_reg   <= tcm_pkg::COUNT_W'(CHIRP_SAMPLES);
                    age_reg    <= '0;
                    cphase_reg <= '0;
                    aq_reg     <= '0;
                    ar_reg     <= '0;
                    rq_reg     <= RQ_W'(REL_Q0);
                    rr_reg     <= RR_W'(REL_R0);
                end
            end
            if (cmd.prep) begin
                pass_reg   <= status.idle_frame;
                active_reg <= (left_reg != '0);
                if (!status.idle_frame) begin
                    tgain_reg <= tcm_pkg::ramp(tgain_reg, tone_target);
                    hgain_reg <= tcm_pkg::ramp(hgain_reg, haz_tgt_reg);
                end
            end
            if (cmd.fin && !pass_reg) begin
                tphase_reg <= tphase_reg + PHASE_BITS'(tone_step_reg);
                hphase_reg <= hphase_reg + PHASE_BITS'(haz_step_reg);
                if (active_reg) begin
                    cphase_reg <= cphase_reg + cinc_reg;
                    age_reg    <= age_reg + 1'b1;
                    left_reg   <= left_reg - 1'b1;
                    if (32'(age_reg) < CHIRP_ATTACK) begin
                        if (ar_inc >= (AR_W+1)'(CHIRP_ATTACK)) begin
                            aq_reg <= aq_reg + 17'(ATT_Q) + 17'd1;
                            ar_reg <= AR_W'(ar_inc - (AR_W+1)'(CHIRP_ATTACK));
                        end else begin
                            aq_reg <= aq_reg + 17'(ATT_Q);
                            ar_reg <= AR_W'(ar_inc);
                        end
                    end
                    if (rr_dec < 0) begin
                        rq_reg <= rq_reg - RQ_W'(REL_Q) - 1'b1;
                        rr_reg <= RR_W'(rr_dec + (RR_W+1)'(CHIRP_RELEASE));
                    end else begin
                        rq_reg <= rq_reg - RQ_W'(REL_Q);
                        rr_reg <= RR_W'(rr_dec);
                    end
                end
            end
        end
    end

    // final sums and output register
    logic signed [18:0] sum_l, sum_r;
    logic signed [15:0] sat_l, sat_r;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    assign sum_l = 19'(in_l_reg) + 19'(tone_reg) + 19'(cl_reg) + 19'(hl_reg);
    assign sum_r = 19'(in_r_reg) + 19'(tone_reg) + 19'(cr_reg) + 19'(hr_reg);
    assign sat_l = (sum_l > 19'sd32767) ? 16'sh7FFF :
                   (sum_l < -19'sd32768) ? 16'sh8000 : sum_l[15:0];
    assign sat_r = (sum_r > 19'sd32767) ? 16'sh7FFF :
                   (sum_r < -19'sd32768) ? 16'sh8000 : sum_r[15:0];

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_tdata_reg <= pass_reg ? {in_r_reg, in_l_reg} : {sat_r, sat_l};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/tone_chirp_mixer_top.sv @@
// Sequence: a silent frame runs event, prepare and commit; when voices sound it runs event, prepare,
// eight multiplier steps and commit. The result is registered at commit.
// A request is taken only while the sequencer is idle, so each frame is finished, with any wait on m_tready
// at commit, before the next is taken; the eight products share one 17x17 multiplier.
// Output register lets the next request enter while a result waits.
// Reset: aresetn synchronous, active low; clears voices, chirp, output valid and config registers to defaults.
module tone_chirp_mixer_top #(
    parameter int PHASE_BITS       = tcm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = tcm_pkg::SINE_DEPTH_DEF,
    parameter int CHIRP_SAMPLES    = tcm_pkg::CHIRP_SAMPLES_DEF,
    parameter int CHIRP_ATTACK     = tcm_pkg::CHIRP_ATTACK_DEF,
    parameter int CHIRP_RELEASE    = tcm_pkg::CHIRP_RELEASE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcm_pkg::STEP_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // in_left, in_right, chirp_step, chirp_level, chirp_pan, 2 zero bits
    input  logic [87:0]                   s_tdata,
    // chirp_start, chirp_stop
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_left, out_right
    output logic [31:0]                   m_tdata
);

    tcm_pkg::cmd_t    cmd;
    tcm_pkg::status_t status;

    tcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcm_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .CHIRP_SAMPLES    (CHIRP_SAMPLES),
        .CHIRP_ATTACK     (CHIRP_ATTACK),
        .CHIRP_RELEASE    (CHIRP_RELEASE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/tcm_checker.sv @@
// tcm_checker: port-level assertions for tone_chirp_mixer_top, bound to it below.
// Watches only the stream handshakes and result data; no package needed.
module tcm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [31:0]                   m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during frame work");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tone_chirp_mixer_top tcm_checker u_tcm_checker (.*);
